// File: design/pcm_pkg.sv
package pcm_pkg;

   // Request fields: poly_ref in tdata, operation in tuser, last in tlast
   localparam int REQ_DATA_BITS = 32;
   localparam int OP_BITS       = 2;

   // Result fields: out_ref, position and new_length in tdata
   localparam int OUT_REF_BITS  = 32;
   localparam int POS_BITS      = 6;
   localparam int LEN_BITS      = 7;
   localparam int RSP_DATA_BITS = 48;

   // Configuration register width (max_path_len)
   localparam int CSR_BITS      = 7;

   // Operation codes carried in req_tuser
   localparam logic [OP_BITS-1:0] OP_START  = 2'd0;
   localparam logic [OP_BITS-1:0] OP_APPEND = 2'd1;
   localparam logic [OP_BITS-1:0] OP_VISIT  = 2'd2;

   // Merge sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SRCH_P,
      ST_SRCH_V,
      ST_SRCH_C,
      ST_CALC,
      ST_TAIL_RD,
      ST_TAIL_WR,
      ST_VIS_RD,
      ST_VIS_WR,
      ST_EMIT_START,
      ST_EMIT_LD,
      ST_EMIT_WAIT
   } state_type;

endpackage

// File: design/path_corridor_merge.sv
// Path corridor merge. Path entries are loaded one per transfer (tuser 0 starts a
// new path, tuser 1 appends), visited entries follow with tuser 2, and the visited
// entry marked with tlast starts a merge: the path is rebuilt from the newest
// visited entries down to the earliest one matching the furthest path entry,
// followed by the path tail, clamped to max_path_len, then emitted one entry per
// transfer. Load transfers leave the block idle and ready. A merge keeps req_tready
// low until the last result has been taken. All steps share the single read port of
// the path and visited memories. The search fetches a path entry, then fetches and
// compares each visited entry in turn; the rebuild copies the tail, then writes the
// visited entries; the output fetches each entry and holds it until rsp_tready. With
// no match the path is emitted unchanged; an empty path gives one empty result.
module path_corridor_merge #(
   parameter int PATH_DEPTH    = 64,
   parameter int VISITED_DEPTH = 16,
   parameter int REF_BITS      = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [pcm_pkg::REQ_DATA_BITS-1:0]  req_tdata,  // [31:0] poly_ref
   input  logic [pcm_pkg::OP_BITS-1:0]        req_tuser,  // [1:0] operation
   input  logic                               req_tlast,
   // result channel
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [pcm_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,  // [31:0] out_ref,
                                                          // [37:32] position,
                                                          // [44:38] new_length
   output logic                               rsp_tuser,  // [0] empty_res
   output logic                               rsp_tlast,
   // configuration write channel
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [pcm_pkg::CSR_BITS-1:0]       csr_data
);

   localparam int PIW = $clog2(PATH_DEPTH);
   localparam int PCW = $clog2(PATH_DEPTH + 1);
   localparam int VIW = (VISITED_DEPTH > 1) ? $clog2(VISITED_DEPTH) : 1;
   localparam int VCW = $clog2(VISITED_DEPTH + 1);
   localparam int SW  = ((PCW > VCW) ? PCW : VCW) + 1;

   // Memories
   logic [REF_BITS-1:0] path_mem [PATH_DEPTH];
   logic [REF_BITS-1:0] vis_mem  [VISITED_DEPTH];

   logic                path_we, path_re, vis_we, vis_re;
   logic [PIW-1:0]      path_wa, path_ra;
   logic [VIW-1:0]      vis_wa, vis_ra;
   logic [REF_BITS-1:0] path_wd, vis_wd;
   logic [REF_BITS-1:0] path_rdata_ff, vis_rdata_ff;

   // Control and bookkeeping registers
   pcm_pkg::state_type      state_ff, state_in;
   logic [PCW-1:0]          plen_ff, plen_in;
   logic [VCW-1:0]          vcnt_ff, vcnt_in;
   logic [pcm_pkg::CSR_BITS-1:0] maxlen_ff;
   logic [PIW-1:0]          i_ff, i_in;
   logic [VIW-1:0]          j_ff, j_in;
   logic [PCW-1:0]          k_ff, k_in;
   logic [PIW-1:0]          hit_path_ff, hit_path_in;
   logic [VIW-1:0]          hit_vis_ff, hit_vis_in;
   logic [PCW-1:0]          req_ff, req_in;
   logic [PCW-1:0]          tail_ff, tail_in;
   logic [PCW-1:0]          orig_ff, orig_in;
   logic                    desc_ff, desc_in;

   // Result register
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [pcm_pkg::OUT_REF_BITS-1:0] rsp_ref_ff, rsp_ref_in;
   logic [pcm_pkg::POS_BITS-1:0]     rsp_pos_ff, rsp_pos_in;
   logic [pcm_pkg::LEN_BITS-1:0]     rsp_len_ff, rsp_len_in;
   logic                             rsp_last_ff, rsp_last_in;
   logic                             rsp_empty_ff, rsp_empty_in;

   // Shared arithmetic
   logic [PCW-1:0] limit;
   logic [PCW-1:0] orig;
   logic [SW-1:0]  req_raw, tail_raw, req_tail_sum;
   logic [PCW-1:0] req_new, tail_new;
   logic [PCW-1:0] tail_pos, tail_src, tail_dst;
   logic [SW-1:0]  vis_rev;
   logic [REF_BITS-1:0] req_ref;
   logic           req_fire, rsp_fire;

   assign req_tready = (state_ff == pcm_pkg::ST_IDLE);
   assign csr_ready  = 1'b1;
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = rsp_valid_ff && rsp_tready;
   assign req_ref    = REF_BITS'(req_tdata);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_len_ff, rsp_pos_ff, rsp_ref_ff};
   assign rsp_tuser  = rsp_empty_ff;
   assign rsp_tlast  = rsp_last_ff;

   // Limit is the smaller of the register and the store depth
   assign limit = (maxlen_ff < PATH_DEPTH) ? PCW'(maxlen_ff) : PCW'(PATH_DEPTH);

   // Lengths of the visited part and of the path tail after the match
   assign orig         = PCW'(hit_path_ff) + PCW'(1);
   assign req_raw      = SW'(vcnt_ff) - SW'(hit_vis_ff);
   assign tail_raw     = SW'(plen_ff) - SW'(orig);
   assign req_tail_sum = req_raw + tail_raw;

   // Clamp to the limit, dropping the tail when the visited part alone overflows
   always_comb begin
      if (req_raw > SW'(limit)) begin
         req_new  = limit;
         tail_new = '0;
      end else if (req_tail_sum > SW'(limit)) begin
         req_new  = PCW'(req_raw);
         tail_new = PCW'(SW'(limit) - req_raw);
      end else begin
         req_new  = PCW'(req_raw);
         tail_new = PCW'(tail_raw);
      end
   end

   // Tail copy walks down when the destination lies above the source
   assign tail_pos = desc_ff ? (tail_ff - k_ff - PCW'(1)) : k_ff;
   assign tail_src = orig_ff + tail_pos;
   assign tail_dst = req_ff + tail_pos;
   assign vis_rev  = SW'(vcnt_ff) - SW'(k_ff) - SW'(1);

   // Memory ports
   always_ff @(posedge clock) begin
      if (path_we) begin
         path_mem[path_wa] <= path_wd;
      end
      if (path_re) begin
         path_rdata_ff <= path_mem[path_ra];
      end
      if (vis_we) begin
         vis_mem[vis_wa] <= vis_wd;
      end
      if (vis_re) begin
         vis_rdata_ff <= vis_mem[vis_ra];
      end
   end

   // State and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pcm_pkg::ST_IDLE;
         plen_ff      <= '0;
         vcnt_ff      <= '0;
         maxlen_ff    <= pcm_pkg::CSR_BITS'(64);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         plen_ff      <= plen_in;
         vcnt_ff      <= vcnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            maxlen_ff <= csr_data;
         end
      end
   end

   // Counters and payload registers
   always_ff @(posedge clock) begin
      i_ff         <= i_in;
      j_ff         <= j_in;
      k_ff         <= k_in;
      hit_path_ff  <= hit_path_in;
      hit_vis_ff   <= hit_vis_in;
      req_ff       <= req_in;
      tail_ff      <= tail_in;
      orig_ff      <= orig_in;
      desc_ff      <= desc_in;
      rsp_ref_ff   <= rsp_ref_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_len_ff   <= rsp_len_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_empty_ff <= rsp_empty_in;
   end

   // Sequencer: next state, memory controls and register updates
   always_comb begin
      state_in     = state_ff;
      plen_in      = plen_ff;
      vcnt_in      = vcnt_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      hit_path_in  = hit_path_ff;
      hit_vis_in   = hit_vis_ff;
      req_in       = req_ff;
      tail_in      = tail_ff;
      orig_in      = orig_ff;
      desc_in      = desc_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_ref_in   = rsp_ref_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_len_in   = rsp_len_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_empty_in = rsp_empty_ff;
      path_we      = 1'b0;
      path_wa      = '0;
      path_wd      = req_ref;
      path_re      = 1'b0;
      path_ra      = '0;
      vis_we       = 1'b0;
      vis_wa       = vcnt_ff[VIW-1:0];
      vis_wd       = req_ref;
      vis_re       = 1'b0;
      vis_ra       = '0;

      case (state_ff)
         // Take load transfers; a final visited entry starts the merge
         pcm_pkg::ST_IDLE: begin
            if (req_fire) begin
               case (req_tuser)
                  pcm_pkg::OP_START: begin
                     path_we = 1'b1;
                     path_wa = '0;
                     plen_in = PCW'(1);
                     vcnt_in = '0;
                  end
                  pcm_pkg::OP_APPEND: begin
                     if (plen_ff < PATH_DEPTH) begin
                        path_we = 1'b1;
                        path_wa = plen_ff[PIW-1:0];
                        plen_in = plen_ff + PCW'(1);
                     end
                  end
                  pcm_pkg::OP_VISIT: begin
                     if (vcnt_ff < VISITED_DEPTH) begin
                        vis_we  = 1'b1;
                        vcnt_in = vcnt_ff + VCW'(1);
                     end
                     if (req_tlast) begin
                        if (plen_ff == '0) begin
                           state_in = pcm_pkg::ST_EMIT_START;
                        end else begin
                           i_in     = PIW'(plen_ff - PCW'(1));
                           state_in = pcm_pkg::ST_SRCH_P;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         // Fetch the path entry under test
         pcm_pkg::ST_SRCH_P: begin
            path_re  = 1'b1;
            path_ra  = i_ff;
            j_in     = '0;
            state_in = pcm_pkg::ST_SRCH_V;
         end

         // Fetch the next visited entry
         pcm_pkg::ST_SRCH_V: begin
            vis_re   = 1'b1;
            vis_ra   = j_ff;
            state_in = pcm_pkg::ST_SRCH_C;
         end

         // Compare; advance visited index, then step the path index down
         pcm_pkg::ST_SRCH_C: begin
            if (path_rdata_ff == vis_rdata_ff) begin
               hit_path_in = i_ff;
               hit_vis_in  = j_ff;
               state_in    = pcm_pkg::ST_CALC;
            end else if ((VCW'(j_ff) + VCW'(1)) < vcnt_ff) begin
               j_in     = j_ff + VIW'(1);
               state_in = pcm_pkg::ST_SRCH_V;
            end else if (i_ff != '0) begin
               i_in     = i_ff - PIW'(1);
               state_in = pcm_pkg::ST_SRCH_P;
            end else begin
               state_in = pcm_pkg::ST_EMIT_START;
            end
         end

         // Size the new path and pick the copy direction
         pcm_pkg::ST_CALC: begin
            req_in   = req_new;
            tail_in  = tail_new;
            orig_in  = orig;
            desc_in  = (req_new > orig);
            plen_in  = req_new + tail_new;
            k_in     = '0;
            state_in = pcm_pkg::ST_TAIL_RD;
         end

         // Move the path tail into place
         pcm_pkg::ST_TAIL_RD: begin
            if (k_ff == tail_ff) begin
               k_in     = '0;
               state_in = pcm_pkg::ST_VIS_RD;
            end else begin
               path_re  = 1'b1;
               path_ra  = tail_src[PIW-1:0];
               state_in = pcm_pkg::ST_TAIL_WR;
            end
         end

         pcm_pkg::ST_TAIL_WR: begin
            path_we  = 1'b1;
            path_wa  = tail_dst[PIW-1:0];
            path_wd  = path_rdata_ff;
            k_in     = k_ff + PCW'(1);
            state_in = pcm_pkg::ST_TAIL_RD;
         end

         // Write visited entries newest first at the head
         pcm_pkg::ST_VIS_RD: begin
            if (k_ff == req_ff) begin
               state_in = pcm_pkg::ST_EMIT_START;
            end else begin
               vis_re   = 1'b1;
               vis_ra   = vis_rev[VIW-1:0];
               state_in = pcm_pkg::ST_VIS_WR;
            end
         end

         pcm_pkg::ST_VIS_WR: begin
            path_we  = 1'b1;
            path_wa  = k_ff[PIW-1:0];
            path_wd  = vis_rdata_ff;
            k_in     = k_ff + PCW'(1);
            state_in = pcm_pkg::ST_VIS_RD;
         end

         // Drop the visited entries and start the output run
         pcm_pkg::ST_EMIT_START: begin
            vcnt_in = '0;
            k_in    = '0;
            if (plen_ff == '0) begin
               rsp_valid_in = 1'b1;
               rsp_ref_in   = '0;
               rsp_pos_in   = '0;
               rsp_len_in   = '0;
               rsp_last_in  = 1'b1;
               rsp_empty_in = 1'b1;
               state_in     = pcm_pkg::ST_EMIT_WAIT;
            end else begin
               path_re  = 1'b1;
               path_ra  = '0;
               state_in = pcm_pkg::ST_EMIT_LD;
            end
         end

         // Load the result register from the fetched entry
         pcm_pkg::ST_EMIT_LD: begin
            rsp_valid_in = 1'b1;
            rsp_ref_in   = pcm_pkg::OUT_REF_BITS'(path_rdata_ff);
            rsp_pos_in   = pcm_pkg::POS_BITS'(k_ff);
            rsp_len_in   = pcm_pkg::LEN_BITS'(plen_ff);
            rsp_last_in  = ((k_ff + PCW'(1)) == plen_ff);
            rsp_empty_in = 1'b0;
            state_in     = pcm_pkg::ST_EMIT_WAIT;
         end

         // Hold the result until the transfer, then fetch the next entry
         pcm_pkg::ST_EMIT_WAIT: begin
            if (rsp_fire) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  state_in = pcm_pkg::ST_IDLE;
               end else begin
                  k_in     = k_ff + PCW'(1);
                  path_re  = 1'b1;
                  path_ra  = PIW'(k_ff + PCW'(1));
                  state_in = pcm_pkg::ST_EMIT_LD;
               end
            end
         end

         default: begin
            state_in = pcm_pkg::ST_IDLE;
         end
      endcase
   end

   // A result is only pending while the sequencer waits on it
   a_rsp_in_wait: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == pcm_pkg::ST_EMIT_WAIT))
      else $error("result valid outside the output wait state");

   // No new request is taken while a result is pending
   a_no_req_with_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !req_tready)
      else $error("request ready while a result is pending");

   // Stored path length never exceeds the store depth
   a_plen_bound: assert property (@(posedge clock) disable iff (reset)
      plen_ff <= PATH_DEPTH)
      else $error("path length beyond store depth");

   // An empty result is a single, final, zero-length result
   a_empty_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_empty_ff) |-> (rsp_last_ff && (rsp_len_ff == '0)))
      else $error("empty result malformed");

   // A merged path length follows the limit after a match
   a_merge_limit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pcm_pkg::ST_CALC) |=> (plen_ff <= $past(limit)))
      else $error("merged path longer than the limit");

endmodule

// File: sim/testbench.sv
module testbench;

   localparam int PATH_DEPTH    = 64;
   localparam int VISIT_DEPTH   = 16;
   localparam int SETTLE_CYCLES = 40;
   localparam int LIMIT_CYCLES  = 800000;
   localparam int NUM_PHASES    = 5;
   localparam logic [pcm_pkg::OP_BITS-1:0] OP_UNUSED = 2'd3;

   typedef struct packed {
      logic [pcm_pkg::OP_BITS-1:0]       op;
      logic [pcm_pkg::REQ_DATA_BITS-1:0] poly_ref;
      logic                              last;
   } corridor_item_type;

   typedef struct packed {
      logic [pcm_pkg::OUT_REF_BITS-1:0] out_ref;
      logic [pcm_pkg::POS_BITS-1:0]     position;
      logic [pcm_pkg::LEN_BITS-1:0]     new_length;
      logic                             is_last;
      logic                             empty_res;
   } path_entry_type;

   logic                              clock      = 1'b0;
   logic                              reset      = 1'b1;
   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   logic [pcm_pkg::REQ_DATA_BITS-1:0] req_tdata  = '0;
   logic [pcm_pkg::OP_BITS-1:0]       req_tuser  = '0;
   logic                              req_tlast  = 1'b0;
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b0;
   logic [pcm_pkg::RSP_DATA_BITS-1:0] rsp_tdata;
   logic                              rsp_tuser;
   logic                              rsp_tlast;
   logic                              csr_valid  = 1'b0;
   logic                              csr_ready;
   logic [pcm_pkg::CSR_BITS-1:0]      csr_data   = '0;

   int send_idle_pct = 0;
   int stall_pct     = 0;
   int fault_count   = 0;
   int counted_items = 0;

   corridor_item_type pending_items[$];
   path_entry_type    expected_path[$];

   // corridor state as the block should hold it
   logic [pcm_pkg::OUT_REF_BITS-1:0] path_mem  [PATH_DEPTH];
   logic [pcm_pkg::OUT_REF_BITS-1:0] visit_mem [VISIT_DEPTH];
   int path_len   = 0;
   int visit_cnt  = 0;
   int path_limit = 64;

   path_corridor_merge #(
      .PATH_DEPTH    (PATH_DEPTH),
      .VISITED_DEPTH (VISIT_DEPTH),
      .REF_BITS      (32)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #6 clock = ~clock;

   // Splice the visited run into the path; return the new path length
   function automatic int splice_visits();
      logic [pcm_pkg::OUT_REF_BITS-1:0] fresh [PATH_DEPTH];
      int  limit, hit_path, hit_vis, keep, tail, orig;
      bit  found;
      limit    = (path_limit < PATH_DEPTH) ? path_limit : PATH_DEPTH;
      found    = 1'b0;
      hit_path = 0;
      hit_vis  = 0;
      // furthest path entry first, earliest visited entry for it
      for (int i = path_len; i > 0 && !found; i--) begin
         for (int j = 0; j < visit_cnt; j++) begin
            if (!found && path_mem[i-1] == visit_mem[j]) begin
               hit_path = i - 1;
               hit_vis  = j;
               found    = 1'b1;
            end
         end
      end
      if (!found)
         return path_len;
      keep = visit_cnt - hit_vis;
      orig = hit_path + 1;
      tail = path_len - orig;
      if (keep > limit) begin
         keep = limit;
         tail = 0;
      end else if (keep + tail > limit) begin
         tail = limit - keep;
      end
      for (int i = 0; i < keep; i++)
         fresh[i] = visit_mem[visit_cnt-1-i];
      for (int i = 0; i < tail; i++)
         fresh[keep+i] = path_mem[orig+i];
      for (int i = 0; i < keep + tail; i++)
         path_mem[i] = fresh[i];
      return keep + tail;
   endfunction

   // Advance the corridor state by one accepted transfer and queue its results
   task automatic advance_corridor(input logic [pcm_pkg::OP_BITS-1:0] op,
                                   input logic [pcm_pkg::REQ_DATA_BITS-1:0] poly,
                                   input logic last);
      int             n;
      path_entry_type e;
      case (op)
         pcm_pkg::OP_START: begin
            path_mem[0] = poly;
            path_len    = 1;
            visit_cnt   = 0;
         end
         pcm_pkg::OP_APPEND: begin
            if (path_len < PATH_DEPTH) begin
               path_mem[path_len] = poly;
               path_len++;
            end
         end
         pcm_pkg::OP_VISIT: begin
            if (visit_cnt < VISIT_DEPTH) begin
               visit_mem[visit_cnt] = poly;
               visit_cnt++;
            end
            if (last) begin
               n         = splice_visits();
               path_len  = n;
               visit_cnt = 0;
               if (n == 0) begin
                  e.out_ref    = '0;
                  e.position   = '0;
                  e.new_length = '0;
                  e.is_last    = 1'b1;
                  e.empty_res  = 1'b1;
                  expected_path.push_back(e);
               end else begin
                  for (int k = 0; k < n; k++) begin
                     e.out_ref    = path_mem[k];
                     e.position   = k[pcm_pkg::POS_BITS-1:0];
                     e.new_length = n[pcm_pkg::LEN_BITS-1:0];
                     e.is_last    = (k + 1 == n);
                     e.empty_res  = 1'b0;
                     expected_path.push_back(e);
                  end
               end
            end
         end
         default: ;
      endcase
   endtask

   task automatic note_fault(input string msg);
      fault_count++;
      if (fault_count <= 10)
         $display("%s", msg);
   endtask

   // Driver: hold each transfer until accepted, gap at random between transfers
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            advance_corridor(req_tuser, req_tdata, req_tlast);
         if (!req_tvalid || req_tready) begin
            if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_tvalid <= 1'b1;
               req_tuser  <= pending_items[0].op;
               req_tdata  <= pending_items[0].poly_ref;
               req_tlast  <= pending_items[0].last;
               void'(pending_items.pop_front());
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each result transfer against the oldest expected entry
   always @(posedge clock) begin
      path_entry_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_path.size() == 0) begin
               note_fault($sformatf("unexpected result: ref %h pos %0d len %0d",
                                    rsp_tdata[31:0], rsp_tdata[37:32], rsp_tdata[44:38]));
            end else begin
               want = expected_path.pop_front();
               if (rsp_tdata[31:0] !== want.out_ref || rsp_tdata[37:32] !== want.position ||
                   rsp_tdata[44:38] !== want.new_length || rsp_tlast !== want.is_last ||
                   rsp_tuser !== want.empty_res)
                  note_fault($sformatf({"result mismatch: expected ref %h pos %0d len %0d ",
                                        "last %0b empty %0b, got ref %h pos %0d len %0d ",
                                        "last %0b empty %0b"},
                                       want.out_ref, want.position, want.new_length,
                                       want.is_last, want.empty_res, rsp_tdata[31:0],
                                       rsp_tdata[37:32], rsp_tdata[44:38], rsp_tlast,
                                       rsp_tuser));
            end
         end
         rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   task automatic push_item(input logic [pcm_pkg::OP_BITS-1:0] op,
                            input logic [pcm_pkg::REQ_DATA_BITS-1:0] poly,
                            input logic last);
      corridor_item_type it;
      it.op       = op;
      it.poly_ref = poly;
      it.last     = last;
      pending_items.push_back(it);
      if (op != OP_UNUSED)
         counted_items++;
   endtask

   // Mix full-range references with a small pool so that matches are frequent
   function automatic logic [pcm_pkg::REQ_DATA_BITS-1:0] pick_ref();
      if ($urandom_range(0, 1))
         return $urandom;
      return $urandom_range(0, 7) | ($urandom_range(0, 1) ? 32'hFFFF_FFF8 : 32'h0);
   endfunction

   // Queue a path load or extension plus visited run, or a burst of noise
   task automatic queue_corridor_run();
      logic [pcm_pkg::REQ_DATA_BITS-1:0] trail[$];
      logic [pcm_pkg::REQ_DATA_BITS-1:0] r;
      int kind, n_app, n_vis;
      kind = $urandom_range(0, 99);
      if (kind < 12) begin
         repeat ($urandom_range(1, 4))
            push_item(pcm_pkg::OP_BITS'($urandom_range(0, 3)), $urandom,
                      1'($urandom_range(0, 1)));
         return;
      end
      if (kind < 75) begin
         r = pick_ref();
         push_item(pcm_pkg::OP_START, r, 1'($urandom_range(0, 1)));
         trail.push_back(r);
      end
      n_app = ($urandom_range(0, 19) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 6);
      repeat (n_app) begin
         r = pick_ref();
         push_item(pcm_pkg::OP_APPEND, r, 1'($urandom_range(0, 1)));
         trail.push_back(r);
      end
      if ($urandom_range(0, 9) == 0)
         push_item(OP_UNUSED, $urandom, 1'($urandom_range(0, 1)));
      n_vis = ($urandom_range(0, 14) == 0) ? $urandom_range(15, 19) : $urandom_range(1, 5);
      for (int v = 0; v < n_vis; v++) begin
         if (trail.size() != 0 && $urandom_range(0, 2) == 0)
            r = trail[$urandom_range(0, trail.size() - 1)];
         else
            r = pick_ref();
         // drop the closing mark now and then so the run carries into the next one
         push_item(pcm_pkg::OP_VISIT, r, (v == n_vis - 1) && ($urandom_range(0, 9) != 0));
      end
   endtask

   task automatic queue_random_runs(input int quota);
      int goal;
      goal = counted_items + quota;
      while (counted_items < goal)
         queue_corridor_run();
   endtask

   // Wait until the block has drained, then let it settle
   task automatic wait_idle();
      do
         @(negedge clock);
      while (pending_items.size() != 0 || req_tvalid || expected_path.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_limit(input int value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value[pcm_pkg::CSR_BITS-1:0];
      do
         @(posedge clock);
      while (!csr_ready);
      csr_valid  <= 1'b0;
      path_limit = value;
   endtask

   task automatic set_idling(input int send_pct, input int recv_pct);
      send_idle_pct <= send_pct;
      stall_pct     <= recv_pct;
      @(negedge clock);
   endtask

   initial begin
      int phase_limit [NUM_PHASES];
      int phase_send  [NUM_PHASES];
      int phase_stall [NUM_PHASES];
      phase_limit = '{3, 1, 0, 127, 0};
      phase_send  = '{51, 0, 31, 31, 51};
      phase_stall = '{0, 51, 31, 31, 0};
      phase_limit[4] = $urandom_range(2, 63);

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: empty path, unused operation, no match, simple and repeated matches
      push_item(pcm_pkg::OP_VISIT, 32'h0000_0000, 1'b1);
      push_item(OP_UNUSED, 32'hFFFF_FFFF, 1'b1);
      push_item(pcm_pkg::OP_START, 32'h0000_0000, 1'b1);
      push_item(pcm_pkg::OP_APPEND, 32'hFFFF_FFFF, 1'b0);
      push_item(pcm_pkg::OP_APPEND, 32'h0000_0005, 1'b1);
      push_item(pcm_pkg::OP_VISIT, 32'h1234_5678, 1'b0);
      push_item(pcm_pkg::OP_VISIT, 32'h8765_4321, 1'b1);
      push_item(pcm_pkg::OP_START, 32'h0000_00A0, 1'b0);
      push_item(pcm_pkg::OP_APPEND, 32'h0000_00B0, 1'b0);
      push_item(pcm_pkg::OP_APPEND, 32'h0000_00C0, 1'b0);
      push_item(pcm_pkg::OP_APPEND, 32'h0000_00D0, 1'b0);
      push_item(pcm_pkg::OP_VISIT, 32'h0000_00E0, 1'b0);
      push_item(pcm_pkg::OP_VISIT, 32'h0000_00C0, 1'b0);
      push_item(pcm_pkg::OP_VISIT, 32'h0000_00F0, 1'b1);
      push_item(pcm_pkg::OP_VISIT, 32'h0000_00F0, 1'b0);
      push_item(pcm_pkg::OP_VISIT, 32'hFFFF_FFFF, 1'b1);
      push_item(pcm_pkg::OP_VISIT, 32'h0000_00D0, 1'b0);
      push_item(pcm_pkg::OP_VISIT, 32'h0000_00C0, 1'b0);
      push_item(pcm_pkg::OP_VISIT, 32'h0000_00D0, 1'b1);
      wait_idle();

      // full path store and full visited store, with the reset limit written back
      write_limit(64);
      set_idling(0, 0);
      push_item(pcm_pkg::OP_START, 32'h1000_0000, 1'b0);
      for (int i = 1; i <= 64; i++)
         push_item(pcm_pkg::OP_APPEND, 32'h1000_0000 + i, i[0]);
      for (int v = 0; v < 17; v++)
         push_item(pcm_pkg::OP_VISIT, (v == 2) ? 32'h1000_003C : 32'h2000_0000 + v, v == 16);
      wait_idle();

      // random phases across limits and idling patterns
      for (int p = 0; p < NUM_PHASES; p++) begin
         write_limit(phase_limit[p]);
         set_idling(phase_send[p], phase_stall[p]);
         queue_random_runs(3);
         wait_idle();
      end

      if (fault_count == 0)
         $display("path_corridor_merge verification clean");
      else
         $display("path_corridor_merge verification failed");
      $finish;
   end

   // Watchdog
   initial begin
      #(LIMIT_CYCLES * 12);
      $display("path_corridor_merge verification failed");
      $finish;
   end

endmodule
